// File: hw/rtl/ipap_pkg.sv
// Shared types and constants for the IP address text parser.
`default_nettype none

package ipap_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam int QUAD_FIELDS = 4;
    localparam int HEX_GROUPS  = 8;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic        valid_res;
        logic        is_ipv6;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } res_item_t;

    // classified character passed from the front end to the parsers
    typedef struct packed {
        logic       last;
        logic       is_digit;
        logic       is_hex;
        logic       is_blank;
        logic       is_dot;
        logic       is_colon;
        logic [3:0] nibble;
    } cls_t;

endpackage

`default_nettype wire

// File: hw/rtl/ipap_front.sv
// Front end: accepts characters and classifies them for the parsers.
`default_nettype none

module ipap_front (
    input  wire logic             push,
    input  wire ipap_pkg::in_item_t item,
    input  wire logic             q_full,
    output logic                  full,
    output logic                  q_push,
    output ipap_pkg::cls_t        q_data
);
    import ipap_pkg::*;

    logic [7:0] c;

    assign c      = item.char_code;
    assign full   = q_full;
    assign q_push = push & ~q_full;

    always_comb
    begin
        q_data          = '0;
        q_data.last     = item.last;
        q_data.is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
        q_data.is_dot   = (c == CHAR_DOT);
        q_data.is_colon = (c == CHAR_COLON);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            q_data.is_digit = 1'b1;
            q_data.is_hex   = 1'b1;
            q_data.nibble   = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            q_data.is_hex = 1'b1;
            q_data.nibble = 4'(c[2:0] + 3'd1) + 4'd8;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ipap_queue.sv
// Short queue of classified characters between front end and parsers.
`default_nettype none

module ipap_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire ipap_pkg::cls_t wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output logic                rd_valid,
    output ipap_pkg::cls_t      rd_data
);
    import ipap_pkg::*;

    cls_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_wr;
    logic                   do_rd;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en & ~full;
    assign do_rd    = rd_en & rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!do_wr && do_rd)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ipap_engine.sv
// Back end: IPv4 and IPv6 parse state, result assembly and result register.
`default_nettype none

module ipap_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire ipap_pkg::cls_t q_data,
    output logic                q_pop,
    output logic                empty,
    input  wire logic           pop,
    output ipap_pkg::res_item_t result
);
    import ipap_pkg::*;

    localparam logic [1:0] QPH_LEAD  = 2'd0;
    localparam logic [1:0] QPH_BLANK = 2'd1;
    localparam logic [1:0] QPH_DIG   = 2'd2;
    localparam logic [1:0] QPH_DONE  = 2'd3;

    localparam logic [1:0] HPH_EMPTY = 2'd0;
    localparam logic [1:0] HPH_BLANK = 2'd1;
    localparam logic [1:0] HPH_DIG   = 2'd2;

    logic        dot_reg,   dot_next;
    logic        start_reg, start_next;
    logic [7:0]  qb_reg    [QUAD_FIELDS];
    logic [7:0]  qb_next   [QUAD_FIELDS];
    logic [1:0]  qidx_reg,  qidx_next;
    logic [1:0]  qph_reg,   qph_next;
    logic        qerr_reg,  qerr_next;
    logic [15:0] hg_reg    [HEX_GROUPS];
    logic [15:0] hg_next   [HEX_GROUPS];
    logic [3:0]  hcnt_reg,  hcnt_next;
    logic [1:0]  hph_reg,   hph_next;
    logic        herr_reg,  herr_next;
    res_item_t   res_reg,   res_next;
    logic        rv_reg,    rv_next;

    logic        take;
    logic        do_start;
    logic [1:0]  f;
    logic [2:0]  g;
    logic        valid;

    assign take   = q_valid & (~q_data.last | ~rv_reg | pop);
    assign q_pop  = take;
    assign empty  = ~rv_reg;
    assign result = res_reg;
    assign f      = qidx_reg;
    assign g      = 3'(hcnt_reg - 4'd1);

    always_comb
    begin
        dot_next   = dot_reg | q_data.is_dot;
        start_next = 1'b0;
        qb_next    = qb_reg;
        qidx_next  = qidx_reg;
        qph_next   = qph_reg;
        qerr_next  = qerr_reg;
        hg_next    = hg_reg;
        hcnt_next  = hcnt_reg;
        hph_next   = hph_reg;
        herr_next  = herr_reg;
        do_start   = 1'b0;

        if (!qerr_reg && qph_reg != QPH_DONE)
        begin
            if (q_data.is_digit)
            begin
                qb_next[f] = qb_reg[f] * 8'd10 + {4'b0, q_data.nibble};
                qph_next   = QPH_DIG;
            end
            else if (q_data.is_blank && qph_reg != QPH_DIG)
            begin
                qph_next = QPH_BLANK;
            end
            else if (f == 2'd3)
            begin
                qph_next = QPH_DONE;
            end
            else if (q_data.is_dot && qph_reg != QPH_BLANK)
            begin
                qidx_next = f + 2'd1;
                qph_next  = QPH_LEAD;
            end
            else
            begin
                qerr_next = 1'b1;
            end
        end

        if (!herr_reg)
        begin
            if (start_reg)
            begin
                if (q_data.is_colon)
                begin
                    hph_next = HPH_EMPTY;
                end
                else
                begin
                    do_start = 1'b1;
                end
            end
            else if (hph_reg == HPH_EMPTY)
            begin
                do_start = 1'b1;
            end
            else if (hph_reg == HPH_BLANK)
            begin
                if (q_data.is_hex)
                begin
                    hg_next[g] = {12'b0, q_data.nibble};
                    hph_next   = HPH_DIG;
                end
                else if (!q_data.is_blank)
                begin
                    herr_next = 1'b1;
                end
            end
            else
            begin
                if (q_data.is_hex)
                begin
                    hg_next[g] = {hg_reg[g][11:0], q_data.nibble};
                end
                else if (q_data.is_colon)
                begin
                    hph_next = HPH_EMPTY;
                end
                else
                begin
                    do_start = 1'b1;
                end
            end

            if (do_start)
            begin
                if (hcnt_reg[3])
                begin
                    herr_next = 1'b1;
                end
                else
                begin
                    hg_next[hcnt_reg[2:0]] = q_data.is_hex ? {12'b0, q_data.nibble} : 16'b0;
                    hcnt_next              = hcnt_reg + 4'd1;
                    if (q_data.is_hex)
                    begin
                        hph_next = HPH_DIG;
                    end
                    else if (q_data.is_blank)
                    begin
                        hph_next = HPH_BLANK;
                    end
                    else if (q_data.is_colon)
                    begin
                        hph_next = HPH_EMPTY;
                    end
                    else
                    begin
                        herr_next = 1'b1;
                    end
                end
            end
        end

        valid = dot_next ? (!qerr_next && qidx_next == 2'd3)
                         : (!herr_next && hph_next != HPH_BLANK);

        res_next           = '0;
        res_next.valid_res = valid;
        res_next.is_ipv6   = ~dot_next;
        if (valid)
        begin
            if (dot_next)
            begin
                res_next.address_high = {qb_next[0], qb_next[1], qb_next[2], qb_next[3],
                                         32'b0};
            end
            else
            begin
                res_next.address_high = {hg_next[0], hg_next[1], hg_next[2], hg_next[3]};
                res_next.address_low  = {hg_next[4], hg_next[5], hg_next[6], hg_next[7]};
            end
        end

        if (take && q_data.last)
        begin
            rv_next = 1'b1;
        end
        else if (pop)
        begin
            rv_next = 1'b0;
        end
        else
        begin
            rv_next = rv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg   <= 1'b0;
            start_reg <= 1'b1;
            qidx_reg  <= '0;
            qph_reg   <= QPH_LEAD;
            qerr_reg  <= 1'b0;
            hcnt_reg  <= '0;
            hph_reg   <= HPH_EMPTY;
            herr_reg  <= 1'b0;
            rv_reg    <= 1'b0;
            for (int i = 0; i < QUAD_FIELDS; i++)
            begin
                qb_reg[i] <= '0;
            end
            for (int i = 0; i < HEX_GROUPS; i++)
            begin
                hg_reg[i] <= '0;
            end
        end
        else
        begin
            rv_reg <= rv_next;
            if (take)
            begin
                if (q_data.last)
                begin
                    dot_reg   <= 1'b0;
                    start_reg <= 1'b1;
                    qidx_reg  <= '0;
                    qph_reg   <= QPH_LEAD;
                    qerr_reg  <= 1'b0;
                    hcnt_reg  <= '0;
                    hph_reg   <= HPH_EMPTY;
                    herr_reg  <= 1'b0;
                    for (int i = 0; i < QUAD_FIELDS; i++)
                    begin
                        qb_reg[i] <= '0;
                    end
                    for (int i = 0; i < HEX_GROUPS; i++)
                    begin
                        hg_reg[i] <= '0;
                    end
                end
                else
                begin
                    dot_reg   <= dot_next;
                    start_reg <= start_next;
                    qidx_reg  <= qidx_next;
                    qph_reg   <= qph_next;
                    qerr_reg  <= qerr_next;
                    hcnt_reg  <= hcnt_next;
                    hph_reg   <= hph_next;
                    herr_reg  <= herr_next;
                    qb_reg    <= qb_next;
                    hg_reg    <= hg_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && q_data.last)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ip_address_text_parser_core.sv
// Top level of the IP address text parser.
`default_nettype none

// Takes one character per cycle while not full and parses it as IPv4 and IPv6
// side by side; a dot anywhere in the text selects IPv4. A character passes
// through a four-entry queue to the parse engine, which takes one per cycle
// unless a text's last character must wait for the previous result's pop.
// The result for a text appears on the result ports in the cycle after its last
// character is taken; the next text's earlier characters are taken meanwhile.
module ip_address_text_parser_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire ipap_pkg::in_item_t  item,
    output logic                     empty,
    input  wire logic                pop,
    output ipap_pkg::res_item_t      result
);
    import ipap_pkg::*;

    logic q_full;
    logic q_push;
    cls_t q_wdata;
    logic q_valid;
    logic q_pop;
    cls_t q_rdata;

    ipap_front u_front (
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .full   (full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    ipap_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wdata),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rdata)
    );

    ipap_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire
